### design/utt_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder package
// Shared types, constants and the code point to UTF-16 conversion function.
// ----------------------------------------------------------------------------
package utt_pkg;

	localparam int UNIT_W = 16;
	localparam int BATCH_N = 4;

	localparam logic [31:0] CP_MAX = 32'h0010_FFFF;
	localparam logic [31:0] BMP_MAX = 32'h0000_FFFF;
	localparam logic [31:0] SURR_LO = 32'h0000_D800;
	localparam logic [31:0] SURR_END = 32'h0000_E000;
	localparam logic [20:0] PLANE1_BASE = 21'h01_0000;
	localparam logic [5:0] HI_SURR_TAG = 6'b110110;
	localparam logic [5:0] LO_SURR_TAG = 6'b110111;

	typedef logic [UNIT_W-1:0] unit_t;

	// Units that one code point turns into, first unit in u0.
	typedef struct packed {
		logic [1:0] n;
		unit_t u0;
		unit_t u1;
	} utt_emit_t;

	// Units that one accepted item turns into, in delivery order.
	typedef struct packed {
		logic [2:0] count;
		unit_t [BATCH_N-1:0] unit;
	} utt_batch_t;

	function automatic utt_emit_t utt_encode(input logic [31:0] cp);
		utt_emit_t e;
		logic [20:0] v;
		v = cp[20:0] - PLANE1_BASE;
		e.n = 2'd0;
		e.u0 = cp[15:0];
		e.u1 = {LO_SURR_TAG, cp[9:0]};
		if (cp > CP_MAX) begin
			e.n = 2'd0;
		end else if (cp > BMP_MAX) begin
			e.n = 2'd2;
			e.u0 = {HI_SURR_TAG, v[19:10]};
		end else if (cp >= SURR_LO && cp < SURR_END) begin
			e.n = 2'd0;
		end else begin
			e.n = 2'd1;
		end
		return e;
	endfunction

endpackage

### design/utt_decode.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder byte decoder
// Registers the incoming byte, keeps the code point accumulator and turns each
// byte into a batch of zero to four UTF-16 units.
// ----------------------------------------------------------------------------
module utt_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	input  logic                in_last,
	output logic                batch_valid,
	input  logic                batch_ready,
	output utt_pkg::utt_batch_t batch
);
	import utt_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic [31:0] acc_q;
	logic       pend_q;

	logic        cont;
	logic        advance;
	logic [31:0] acc_next;
	utt_emit_t   e1;
	utt_emit_t   e2;
	utt_emit_t   enc_old;
	utt_emit_t   enc_new;

	assign advance = valid_s1 && batch_ready;
	assign in_ready = !valid_s1 || batch_ready;
	assign batch_valid = valid_s1;

	assign cont = (byte_s1[7:6] == 2'b10);

	always_comb begin
		if (byte_s1[7] == 1'b0) begin
			acc_next = {24'd0, byte_s1};
		end else if (cont) begin
			acc_next = {acc_q[25:0], byte_s1[5:0]};
		end else if (byte_s1[5] == 1'b0) begin
			acc_next = {27'd0, byte_s1[4:0]};
		end else if (byte_s1[4] == 1'b0) begin
			acc_next = {28'd0, byte_s1[3:0]};
		end else begin
			acc_next = {29'd0, byte_s1[2:0]};
		end
	end

	assign enc_old = utt_encode(acc_q);
	assign enc_new = utt_encode(acc_next);

	always_comb begin
		e1 = enc_old;
		e2 = enc_new;
		if (cont || !pend_q) begin
			e1.n = 2'd0;
		end
		if (!last_s1) begin
			e2.n = 2'd0;
		end
		batch.count = {1'b0, e1.n} + {1'b0, e2.n};
		batch.unit[3] = e2.u1;
		case (e1.n)
			2'd1: begin
				batch.unit[0] = e1.u0;
				batch.unit[1] = e2.u0;
				batch.unit[2] = e2.u1;
			end
			2'd2: begin
				batch.unit[0] = e1.u0;
				batch.unit[1] = e1.u1;
				batch.unit[2] = e2.u0;
			end
			default: begin
				batch.unit[0] = e2.u0;
				batch.unit[1] = e2.u1;
				batch.unit[2] = e2.u1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 32'd0;
			pend_q <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				acc_q <= 32'd0;
				pend_q <= 1'b0;
			end else begin
				acc_q <= acc_next;
				pend_q <= 1'b1;
			end
		end
	end

endmodule

### design/utt_outbuf.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder output buffer
// Holds the units of one batch and hands them out one item per cycle while
// out_ready is high, marking the last unit of the batch.
// ----------------------------------------------------------------------------
module utt_outbuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                batch_valid,
	output logic                batch_ready,
	input  utt_pkg::utt_batch_t batch,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [15:0]         out_unit,
	output logic                out_last
);
	import utt_pkg::*;

	unit_t      unit_q [BATCH_N];
	logic [2:0] cnt_q;
	logic [1:0] rd_q;
	logic       take;
	logic       load;

	assign out_valid = (cnt_q != 3'd0);
	assign out_unit = unit_q[rd_q];
	assign out_last = (cnt_q == 3'd1);
	assign take = out_valid && out_ready;
	assign batch_ready = (cnt_q == 3'd0) || (cnt_q == 3'd1 && out_ready);
	assign load = batch_valid && batch_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			rd_q <= 2'd0;
		end else if (load) begin
			cnt_q <= batch.count;
			rd_q <= 2'd0;
		end else if (take) begin
			cnt_q <= cnt_q - 3'd1;
			rd_q <= rd_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < BATCH_N; i++) begin
				unit_q[i] <= batch.unit[i];
			end
		end
	end

endmodule

### design/utf8_to_utf16_transcoder_top.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder
// Decodes a UTF-8 byte stream into UTF-16 code units.
//
// Channel  Dir  tdata                 tlast
// s_*      in   [7:0] in_byte         string_last
// m_*      out  [15:0] utf16_unit     run_last
//
// A byte is registered, decoded against the accumulator and its units are
// loaded into a four-entry output buffer. A byte that gives at most one unit
// does not hold the decoder, so one byte per cycle is sustained while m_tready
// is high; a byte that gives more units holds it while the buffer drains.
// Reset clears the accumulator, the pending flag and all valid flags.
// A stall on m_tready backs up through the buffer and the input register.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] utf16_unit
	output logic        m_tlast
);
	import utt_pkg::*;

	utt_batch_t batch;
	logic       batch_valid;
	logic       batch_ready;

	utt_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_byte     (s_tdata),
		.in_last     (s_tlast),
		.batch_valid (batch_valid),
		.batch_ready (batch_ready),
		.batch       (batch)
	);

	utt_outbuf u_outbuf (
		.clk         (clk),
		.arst_n      (arst_n),
		.batch_valid (batch_valid),
		.batch_ready (batch_ready),
		.batch       (batch),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_unit    (m_tdata),
		.out_last    (m_tlast)
	);

endmodule

### tb/utt_transcode_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder checker
// Watches the byte and unit channels and decodes each accepted byte on its
// own copy of the accumulator. Each unit that it predicts waits in order until
// the block delivers a unit, which it then compares in value and end flag.
// ----------------------------------------------------------------------------
module utt_transcode_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,
	input  logic        m_tlast,
	output int          errors,
	output int          units_due
);
	import utt_pkg::*;

	typedef struct packed {
		unit_t unit;
		logic  last;
	} owed_unit_t;

	owed_unit_t  units_owed[$];
	owed_unit_t  head;
	unit_t       batch[$];
	logic [31:0] code_accum;
	logic        code_open;

	function automatic void emit_code_point(input logic [31:0] cp);
		logic [31:0] v;
		v = cp - 32'h0001_0000;
		if (cp > CP_MAX) begin
			return;
		end
		if (cp > BMP_MAX) begin
			batch = {batch, unit_t'(32'h0000_D800 + (v >> 10))};
			batch = {batch, unit_t'(32'h0000_DC00 + (cp & 32'h0000_03FF))};
		end else if (!(cp >= SURR_LO && cp < SURR_END)) begin
			batch = {batch, cp[15:0]};
		end
	endfunction

	task automatic decode_byte(input logic [7:0] b, input logic fin);
		owed_unit_t item;
		batch.delete();
		if (b[7:6] != 2'b10 && code_open) begin
			emit_code_point(code_accum);
		end
		if (b <= 8'h7f) begin
			code_accum = {24'd0, b};
		end else if (b <= 8'hbf) begin
			code_accum = {code_accum[25:0], b[5:0]};
		end else if (b <= 8'hdf) begin
			code_accum = {27'd0, b[4:0]};
		end else if (b <= 8'hef) begin
			code_accum = {28'd0, b[3:0]};
		end else begin
			code_accum = {29'd0, b[2:0]};
		end
		code_open = 1'b1;
		if (fin) begin
			emit_code_point(code_accum);
			code_accum = '0;
			code_open = 1'b0;
		end
		foreach (batch[i]) begin
			item.unit = batch[i];
			item.last = (i == batch.size() - 1);
			units_owed = {units_owed, item};
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			units_owed.delete();
			code_accum = '0;
			code_open = 1'b0;
			errors = 0;
			units_due = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (units_owed.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("%0t: unexpected unit %h last %b", $realtime, m_tdata, m_tlast);
					end
				end else begin
					head = units_owed.pop_front();
					if (m_tdata !== head.unit || m_tlast !== head.last) begin
						errors++;
						if (errors <= 10) begin
							$display("%0t: unit mismatch, expected %h last %b, got %h last %b",
								$realtime, head.unit, head.last, m_tdata, m_tlast);
						end
					end
				end
			end
			if (s_tvalid && s_tready) begin
				decode_byte(s_tdata, s_tlast);
			end
			units_due = units_owed.size();
		end
	end

endmodule

### tb/tb_utf8_to_utf16_transcoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder testbench
// Sends directed byte strings for the edge cases of the decoder, then random
// characters, some out of range or overlong, mixed with truncated sequences and
// noise bytes, under bursty input and a stalling output. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_utf8_to_utf16_transcoder_top;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int LONG_HOLD = 300;
	localparam int BYTES_TOTAL = 150;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;

	int   errors;
	int   units_due;
	int   bytes_sent = 0;
	int   burst_left = 0;
	int   idle_cycles = 0;
	logic hold_req = 1'b0;

	utf8_to_utf16_transcoder_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	utt_transcode_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.errors    (errors),
		.units_due (units_due)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		@(posedge arst_n);
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int rx_cnt;
		int rx_mode;
		bit hold_taken;
		rx_cnt = 0;
		rx_mode = 0;
		hold_taken = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else begin
				rx_cnt++;
				if (rx_cnt % 64 == 0) begin
					rx_mode = $urandom_range(0, 3);
				end
				case (rx_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= rx_cnt[2];
				endcase
			end
		end
	end

	// Entered and left at a falling edge.
	task automatic push_byte(input logic [7:0] b, input logic fin);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= fin;
		do @(posedge clk); while (!(s_tvalid && s_tready));
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic pause_until_drained();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (units_due != 0);
	endtask

	// Encodes cp in len bytes and sends the first keep of them.
	task automatic send_char(input logic [31:0] cp, input int len, input int keep,
			input logic fin);
		logic [7:0] seq[4];
		case (len)
			1: seq[0] = {1'b0, cp[6:0]};
			2: begin
				seq[0] = {3'b110, cp[10:6]};
				seq[1] = {2'b10, cp[5:0]};
			end
			3: begin
				seq[0] = {4'b1110, cp[15:12]};
				seq[1] = {2'b10, cp[11:6]};
				seq[2] = {2'b10, cp[5:0]};
			end
			default: begin
				seq[0] = {5'b11110, cp[20:18]};
				seq[1] = {2'b10, cp[17:12]};
				seq[2] = {2'b10, cp[11:6]};
				seq[3] = {2'b10, cp[5:0]};
			end
		endcase
		for (int i = 0; i < keep; i++) begin
			push_byte(seq[i], fin && (i == keep - 1));
		end
	endtask

	initial begin
		int len;
		logic [31:0] cp;
		logic fin;
		bit hold_done;
		bit drain_done;
		hold_done = 0;
		drain_done = 0;
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		push_byte(8'h00, 1'b0);
		push_byte(8'h7f, 1'b1);
		push_byte(8'hc3, 1'b0);
		push_byte(8'ha9, 1'b0);
		push_byte(8'he2, 1'b0);
		push_byte(8'h82, 1'b0);
		push_byte(8'hac, 1'b1);
		push_byte(8'hf0, 1'b0);
		push_byte(8'h9f, 1'b0);
		push_byte(8'h98, 1'b0);
		push_byte(8'h80, 1'b1);
		push_byte(8'hf4, 1'b0);
		push_byte(8'h8f, 1'b0);
		push_byte(8'hbf, 1'b0);
		push_byte(8'hbf, 1'b0);
		push_byte(8'hf4, 1'b0);
		push_byte(8'h90, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'hed, 1'b0);
		push_byte(8'ha0, 1'b0);
		push_byte(8'h80, 1'b1);
		push_byte(8'hbf, 1'b1);
		push_byte(8'hff, 1'b1);

		while (bytes_sent < BYTES_TOTAL) begin
			if (!hold_done && bytes_sent >= 70) begin
				hold_done = 1;
				hold_req = 1'b1;
				burst_left = 60;
			end
			if (!drain_done && bytes_sent >= 130) begin
				drain_done = 1;
				pause_until_drained();
			end
			fin = ($urandom_range(0, 4) == 0);
			len = $urandom_range(1, 4);
			case (len)
				1: cp = $urandom_range(0, 32'h7f);
				2: cp = $urandom_range(0, 32'h7ff);
				3: cp = $urandom_range(0, 32'hffff);
				default: cp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'h1f_ffff)
					: $urandom_range(32'h1_0000, 32'h10_ffff);
			endcase
			case ($urandom_range(0, 9))
				0: push_byte(8'($urandom_range(0, 255)), fin);
				1: send_char(cp, len, $urandom_range(1, len), fin);
				default: send_char(cp, len, len, fin);
			endcase
		end

		pause_until_drained();
		repeat (20) @(negedge clk);
		if (errors == 0 && units_due == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
